/* rtl/rmst_pkg.sv */
package rmst_pkg;

    localparam int RMST_MAX_ELEMENTS = 1024;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 11;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic signed [VAL_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DESC,
        ST_LEAF,
        ST_UP,
        ST_ROOT,
        ST_QRY,
        ST_QFIN
    } t_state;

endpackage

/* rtl/range_minimum_segment_tree_top.sv */
// Range-minimum segment tree over up to MAX_ELEMENTS signed 32-bit elements, held as an
// implicit heap in one synchronous memory of 4*MAX_ELEMENTS words. After reset the block
// runs a clearing pass over every word with busy high; configuration transfers are taken
// at any time. A load or add walks down to the leaf at one node a cycle and then climbs
// back to the root at one node a cycle, the memory port writing each node it reaches and,
// below the root, reading that node's sibling; busy stays high throughout. A query walks
// the tree depth first with a small node stack, one node a cycle, with busy high; an
// empty span, an unused command or a position past the end keeps busy high for one cycle.
// Each item gives exactly one result, shown for one cycle with o_done in the first cycle
// after busy falls; the receiver cannot stall, and a new item may start in that cycle.
module range_minimum_segment_tree_top #(
    parameter int MAX_ELEMENTS = rmst_pkg::RMST_MAX_ELEMENTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rmst_pkg::CMD_W-1:0]          i_cmd,
    input  logic [rmst_pkg::IDX_W-1:0]          i_position,
    input  logic signed [rmst_pkg::VAL_W-1:0]   i_value,
    input  logic [rmst_pkg::IDX_W-1:0]          i_range_low,
    input  logic [rmst_pkg::IDX_W-1:0]          i_range_high,
    output logic                                o_done,
    output logic signed [rmst_pkg::VAL_W-1:0]   o_result_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rmst_pkg::CNT_W-1:0]          i_cfg_data
);
    import rmst_pkg::*;

    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int XW    = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam int DEPTH = 4 * MAX_ELEMENTS;
    localparam int NW    = $clog2(DEPTH);
    localparam int SIW   = $clog2(IW + 1);
    localparam int SD    = 2 ** SIW;

    typedef struct packed {
        logic [NW-1:0] node;
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;
    } t_frame;

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_count;
    logic                    r_add, n_add;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [XW-1:0]           r_pos, n_pos;
    logic [XW-1:0]           r_l, n_l;
    logic [XW-1:0]           r_r, n_r;
    logic [NW-1:0]           r_node, n_node;
    logic [IW-1:0]           r_lo, n_lo;
    logic [IW-1:0]           r_hi, n_hi;
    logic signed [VAL_W-1:0] r_cur, n_cur;
    logic signed [VAL_W-1:0] r_acc, n_acc;
    logic                    r_qpend, n_qpend;
    logic [SIW:0]            r_sp, n_sp;
    t_frame                  r_stack [SD];
    logic [NW-1:0]           r_clr, n_clr;
    logic                    r_done, n_done;
    logic signed [VAL_W-1:0] r_result, n_result;

    logic signed [VAL_W-1:0] r_tree [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;
    logic [NW-1:0]           rd_addr;
    logic                    wr_en;
    logic [NW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic                    push_en;
    t_frame                  push_frame;

    // Decode and node arithmetic shared by both combinational blocks.
    logic [XW-1:0]           cnt_x;
    logic [XW-1:0]           n_act;
    logic [IW-1:0]           top_idx;
    logic                    accept;
    logic                    pos_ok;
    logic                    q_empty;
    logic [IW:0]             sum_lh;
    logic [IW-1:0]           mid;
    logic [NW-1:0]           left_node;
    logic [NW-1:0]           right_node;
    logic [NW-1:0]           parent_node;
    logic [NW-1:0]           sib_node;
    logic                    at_leaf;
    logic                    at_root;
    logic                    q_disjoint;
    logic                    q_cover;
    logic [SIW:0]            sp_m1;
    t_frame                  pop_frame;
    logic signed [VAL_W-1:0] leaf_new;
    logic signed [VAL_W-1:0] up_new;
    logic signed [VAL_W-1:0] acc_fold;

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_result_value = r_result;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cnt_x   = XW'(r_count);
        if (cnt_x == '0) begin
            n_act = XW'(1);
        end else if (cnt_x > XW'(MAX_ELEMENTS)) begin
            n_act = XW'(MAX_ELEMENTS);
        end else begin
            n_act = cnt_x;
        end
        top_idx = IW'(n_act - XW'(1));
        accept  = start && !busy;
        pos_ok  = XW'(i_position) < n_act;
        q_empty = (i_range_low > i_range_high) || (XW'(i_range_low) >= n_act);

        sum_lh      = {1'b0, r_lo} + {1'b0, r_hi};
        mid         = sum_lh[IW:1];
        left_node   = {r_node[NW-2:0], 1'b0} + NW'(1);
        right_node  = {r_node[NW-2:0], 1'b0} + NW'(2);
        parent_node = (r_node - NW'(1)) >> 1;
        // Odd nodes are left children, so the sibling sits one above.
        sib_node    = r_node[0] ? (r_node + NW'(1)) : (r_node - NW'(1));
        at_leaf     = (r_lo == r_hi);
        at_root     = (r_node == '0);
        q_disjoint  = (r_l > XW'(r_hi)) || (r_r < XW'(r_lo));
        q_cover     = (r_l <= XW'(r_lo)) && (XW'(r_hi) <= r_r);
        sp_m1       = r_sp - (SIW + 1)'(1);
        pop_frame   = r_stack[sp_m1[SIW-1:0]];

        leaf_new = r_add ? (r_rdata + r_val) : r_val;
        up_new   = (r_cur < r_rdata) ? r_cur : r_rdata;
        acc_fold = (r_qpend && (r_rdata < r_acc)) ? r_rdata : r_acc;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == NW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_LOAD, CMD_ADD: n_state = pos_ok ? ST_DESC : ST_ROOT;
                        CMD_QUERY:         n_state = q_empty ? ST_QFIN : ST_QRY;
                        default:           n_state = ST_ROOT;
                    endcase
                end
            end
            ST_DESC: begin
                if (at_leaf) begin
                    n_state = ST_LEAF;
                end
            end
            ST_LEAF, ST_UP: begin
                n_state = at_root ? ST_IDLE : ST_UP;
            end
            ST_ROOT: n_state = ST_IDLE;
            ST_QRY: begin
                if ((q_disjoint || q_cover) && (r_sp == '0)) begin
                    n_state = ST_QFIN;
                end
            end
            ST_QFIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_add      = r_add;
        n_val      = r_val;
        n_pos      = r_pos;
        n_l        = r_l;
        n_r        = r_r;
        n_node     = r_node;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_cur      = r_cur;
        n_acc      = r_qpend ? acc_fold : r_acc;
        n_qpend    = 1'b0;
        n_sp       = r_sp;
        n_clr      = r_clr;
        n_done     = 1'b0;
        n_result   = r_result;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = r_node;
        wr_data    = leaf_new;
        push_en    = 1'b0;
        push_frame = '{node: right_node, lo: mid + IW'(1), hi: r_hi};

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = TOP_VALUE;
                n_clr   = r_clr + NW'(1);
            end
            ST_IDLE: begin
                // The root is read here so that a command that changes nothing has it next.
                if (accept) begin
                    n_add   = (i_cmd == CMD_ADD);
                    n_val   = i_value;
                    n_pos   = XW'(i_position);
                    n_l     = XW'(i_range_low);
                    n_r     = XW'(i_range_high);
                    n_node  = '0;
                    n_lo    = '0;
                    n_hi    = top_idx;
                    n_sp    = '0;
                    n_acc   = TOP_VALUE;
                end
            end
            ST_DESC: begin
                if (at_leaf) begin
                    rd_addr = r_node;
                end else if (r_pos <= XW'(mid)) begin
                    n_node = left_node;
                    n_hi   = mid;
                end else begin
                    n_node = right_node;
                    n_lo   = mid + IW'(1);
                end
            end
            ST_LEAF: begin
                wr_en   = 1'b1;
                wr_data = leaf_new;
                n_cur   = leaf_new;
                if (at_root) begin
                    n_done   = 1'b1;
                    n_result = leaf_new;
                end else begin
                    rd_addr = sib_node;
                    n_node  = parent_node;
                end
            end
            ST_UP: begin
                wr_en   = 1'b1;
                wr_data = up_new;
                n_cur   = up_new;
                if (at_root) begin
                    n_done   = 1'b1;
                    n_result = up_new;
                end else begin
                    rd_addr = sib_node;
                    n_node  = parent_node;
                end
            end
            ST_ROOT: begin
                n_done   = 1'b1;
                n_result = r_rdata;
            end
            ST_QRY: begin
                if (q_disjoint || q_cover) begin
                    if (q_cover && !q_disjoint) begin
                        rd_addr = r_node;
                        n_qpend = 1'b1;
                    end
                    if (r_sp != '0) begin
                        n_node = pop_frame.node;
                        n_lo   = pop_frame.lo;
                        n_hi   = pop_frame.hi;
                        n_sp   = sp_m1;
                    end
                end else begin
                    // Partial overlap: keep the right half for later and go left.
                    push_en = 1'b1;
                    n_sp    = r_sp + (SIW + 1)'(1);
                    n_node  = left_node;
                    n_hi    = mid;
                end
            end
            ST_QFIN: begin
                n_done   = 1'b1;
                n_result = acc_fold;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_qpend <= 1'b0;
            r_sp    <= '0;
            r_count <= COUNT_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            r_qpend <= n_qpend;
            r_sp    <= n_sp;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_add    <= n_add;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_l      <= n_l;
        r_r      <= n_r;
        r_node   <= n_node;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_cur    <= n_cur;
        r_acc    <= n_acc;
        r_result <= n_result;
        if (push_en) begin
            r_stack[r_sp[SIW-1:0]] <= push_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tree[wr_addr] <= wr_data;
        end
        r_rdata <= r_tree[rd_addr];
    end

endmodule

/* rtl/rmst_checker.sv */
module rmst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // Every accepted transfer makes the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transfer");

    // A result is shown only once the block has finished its item.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // Each item keeps busy high before its result is shown, so results never come back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // Reset starts the clearing pass, during which nothing is accepted.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_done))
        else $error("block not clearing after reset");

endmodule

bind range_minimum_segment_tree_top rmst_checker u_rmst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
